// ===== src/lou_pkg.sv =====
// Shared types, constants and fixed-point helpers for the OVRVO axis update block.
package lou_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 24;
  localparam int MASS_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int RAD_W     = MASS_W + FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int KDEN_W    = MASS_W + 1;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP      = 3'd0,
    REG_FRICTION_SCALE = 3'd1,
    REG_VELOCITY_DECAY = 3'd2,
    REG_NOISE_SCALE    = 3'd3,
    REG_THERMOSTAT_X   = 3'd4,
    REG_THERMOSTAT_Y   = 3'd5,
    REG_THERMOSTAT_Z   = 3'd6
  } cfg_reg_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [COEF_W-1:0] time_step;
    logic [COEF_W-1:0] friction_scale;
    logic [COEF_W-1:0] velocity_decay;
    logic [COEF_W-1:0] noise_scale;
    logic              thermostat_x;
    logic              thermostat_y;
    logic              thermostat_z;
  } cfg_t;

  // Per-item fields that ride along the square root and kick divider pipelines.
  typedef struct packed {
    logic                     cmd;
    logic                     thermo;
    logic [COEF_W-1:0]        k;
    logic [MASS_W-1:0]        mass;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] t;
  } side_t;

  function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] a);
    mag_of = a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(a)) : DATA_W'(a);
  endfunction

  // Clamp a magnitude with a sign into the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
    logic [DATA_W-1:0] low;
    low = m[DATA_W-1:0];
    if (neg) begin
      if (m >= 64'(DATA_MIN[DATA_W-1:0])) return DATA_MIN;
      return DATA_W'(0) - low;
    end
    if (m >= 64'(DATA_MAX[DATA_W-1:0])) return DATA_MAX;
    return low;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? DATA_MIN : DATA_MAX;
    return s[DATA_W-1:0];
  endfunction

  // Second half of a data-by-coefficient multiply: drop the coefficient fraction.
  function automatic logic signed [DATA_W-1:0] coef_scale(input logic [PROD_W-1:0] p,
                                                         input logic neg);
    return sat_mag(64'(p[PROD_W-1:COEF_FRAC]), neg);
  endfunction

endpackage

// ===== src/lou_cfg.sv =====
// Configuration registers and the thermostatted step coefficient.
module lou_cfg
  import lou_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output cfg_t                 cfg,
  output logic [COEF_W-1:0]    k_therm
);

  logic [PROD_W-1:0] kp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step      <= '0;
      cfg.friction_scale <= COEF_W'(1) << COEF_FRAC;
      cfg.velocity_decay <= COEF_W'(1) << COEF_FRAC;
      cfg.noise_scale    <= '0;
      cfg.thermostat_x   <= 1'b0;
      cfg.thermostat_y   <= 1'b0;
      cfg.thermostat_z   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP:      cfg.time_step      <= cfg_data;
        REG_FRICTION_SCALE: cfg.friction_scale <= cfg_data;
        REG_VELOCITY_DECAY: cfg.velocity_decay <= cfg_data;
        REG_NOISE_SCALE:    cfg.noise_scale    <= cfg_data;
        REG_THERMOSTAT_X:   cfg.thermostat_x   <= cfg_data[0];
        REG_THERMOSTAT_Y:   cfg.thermostat_y   <= cfg_data[0];
        REG_THERMOSTAT_Z:   cfg.thermostat_z   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign kp = cfg.friction_scale * cfg.time_step;

  // Friction times step, saturated, registered behind the config registers.
  always_ff @(posedge clk) begin
    if (|kp[PROD_W-1:COEF_FRAC+COEF_W]) k_therm <= '1;
    else k_therm <= kp[COEF_FRAC+COEF_W-1:COEF_FRAC];
  end

endmodule

// ===== src/lou_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module lou_sqrt_pipe
  import lou_pkg::*;
#(
  parameter int IN_W   = 48,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 2;

  logic [OUT_W-1:0]  vld;
  logic [RW-1:0]     rem_q  [OUT_W];
  logic [OUT_W-1:0]  root_q [OUT_W];
  logic [IN_W-1:0]   rad_q  [OUT_W];
  logic [SIDE_W-1:0] side_q [OUT_W];

  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    logic              p_valid;
    logic [RW-1:0]     p_rem;
    logic [OUT_W-1:0]  p_root;
    logic [IN_W-1:0]   p_rad;
    logic [SIDE_W-1:0] p_side;
    logic [RW-1:0]     trial_rem;
    logic [RW-1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = '0;
      assign p_root  = '0;
      assign p_rad   = radicand;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = vld[i-1];
      assign p_rem   = rem_q[i-1];
      assign p_root  = root_q[i-1];
      assign p_rad   = rad_q[i-1];
      assign p_side  = side_q[i-1];
    end

    assign trial_rem = {p_rem[RW-3:0], p_rad[IN_W-1:IN_W-2]};
    assign trial     = {p_root, 2'b01};
    assign ge        = trial_rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (en) vld[i] <= p_valid;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? (trial_rem - trial) : trial_rem;
        root_q[i] <= {p_root[OUT_W-2:0], ge};
        rad_q[i]  <= {p_rad[IN_W-3:0], 2'b00};
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld[OUT_W-1];
  assign root      = root_q[OUT_W-1];
  assign out_side  = side_q[OUT_W-1];

endmodule

// ===== src/lou_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module lou_div_pipe
  import lou_pkg::*;
#(
  parameter int NW     = 48,
  parameter int DW     = 24,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     numer,
  input  logic [DW-1:0]     denom,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NW-1:0]     quot,
  output logic [SIDE_W-1:0] out_side
);

  logic [NW-1:0]     vld;
  logic [DW-1:0]     rem_q  [NW];
  logic [NW-1:0]     nq_q   [NW];
  logic [DW-1:0]     den_q  [NW];
  logic [SIDE_W-1:0] side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic              p_valid;
    logic [DW-1:0]     p_rem;
    logic [NW-1:0]     p_nq;
    logic [DW-1:0]     p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DW:0]       sh;
    logic [DW:0]       diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_rem   = '0;
      assign p_nq    = numer;
      assign p_den   = denom;
      assign p_side  = in_side;
    end else begin : g_next
      assign p_valid = vld[i-1];
      assign p_rem   = rem_q[i-1];
      assign p_nq    = nq_q[i-1];
      assign p_den   = den_q[i-1];
      assign p_side  = side_q[i-1];
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    assign sh   = {p_rem, p_nq[NW-1]};
    assign diff = sh - {1'b0, p_den};
    assign ge   = sh >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (en) vld[i] <= p_valid;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
        nq_q[i]   <= {p_nq[NW-2:0], ge};
        den_q[i]  <= p_den;
        side_q[i] <= p_side;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quot      = nq_q[NW-1];
  assign out_side  = side_q[NW-1];

endmodule

// ===== src/langevin_ovrvo_axis_update.sv =====
// Top level of the OVRVO Langevin axis update: input stages, root/divide pipes, update chain.
//
// Each word updates one axis of one atom: the first half step (command 0) applies the
// thermostat noise, the kick and the drift; the second half (command 1) applies the kick
// and then the noise and passes the position through. The block accepts one word every
// clock while item_stall is low; each word passes the 24-stage square root of the mass
// and then the 48-stage dividers for the kick and the noise factor, with multiply
// stages around them. A skid register behind the output register lets one more word
// leave the pipeline while a result waits; item_stall rises only once that register is
// occupied. Configuration may be written only while no word is in flight.
module langevin_ovrvo_axis_update
  import lou_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     command,
  input  logic [1:0]               axis,
  input  logic [MASS_W-1:0]        atom_mass,
  input  logic signed [DATA_W-1:0] position_in,
  input  logic signed [DATA_W-1:0] velocity_in,
  input  logic signed [DATA_W-1:0] force_in,
  input  logic signed [DATA_W-1:0] gauss_sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] velocity_out,
  output logic signed [DATA_W-1:0] position_out
);

  localparam int SIDE_W = $bits(side_t);

  typedef struct packed {
    logic                     cmd;
    logic                     thermo;
    logic [COEF_W-1:0]        k;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] kick;
    logic [COEF_W-1:0]        c;
  } post_t;

  cfg_t              cfg;
  logic [COEF_W-1:0] k_therm;
  logic              en;
  logic              skid_full;

  // Input stage.
  logic                     s0_valid;
  logic                     s0_cmd;
  logic [1:0]               s0_axis;
  logic [MASS_W-1:0]        s0_mass;
  logic signed [DATA_W-1:0] s0_x, s0_v, s0_f, s0_g;
  logic                     s0_thermo;

  // Force times step.
  logic              s1_valid;
  side_t             s1_side;
  logic [PROD_W-1:0] s1_pf;
  logic              s1_fneg;

  logic  s2_valid;
  side_t s2_side;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side_bits;
  side_t             sq_side;

  logic              kd_valid;
  logic [NUM_W-1:0]  kd_quot;
  logic [SIDE_W-1:0] kd_side_bits;
  side_t             kd_side;
  logic              cd_valid;
  logic [NUM_W-1:0]  cd_quot;
  logic              cd_mass_zero;

  logic                     e0_valid, e1_valid, e2_valid, e3_valid, e4_valid, e5_valid;
  logic                     e6_valid;
  post_t                    e0, e1, e2, e3, e4, e5;
  logic signed [DATA_W-1:0] e0_v, e1_u, e2_u, e3_w, e4_y, e5_y;
  logic [PROD_W-1:0]        e2_pv, e2_pg, e5_px;
  logic                     e2_pvn, e2_pgn, e5_pxn;
  logic signed [DATA_W-1:0] e6_v, e6_x;

  logic                     arrive;
  logic signed [DATA_W-1:0] skid_v, skid_x;

  lou_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .k_therm   (k_therm)
  );

  assign en         = !skid_full;
  assign item_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= item_valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd  <= command;
      s0_axis <= axis;
      s0_mass <= atom_mass;
      s0_x    <= position_in;
      s0_v    <= velocity_in;
      s0_f    <= force_in;
      s0_g    <= gauss_sample;
    end
  end

  always_comb begin
    case (s0_axis)
      AXIS_X:  s0_thermo = cfg.thermostat_x;
      AXIS_Y:  s0_thermo = cfg.thermostat_y;
      AXIS_Z:  s0_thermo = cfg.thermostat_z;
      default: s0_thermo = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.cmd    <= s0_cmd;
      s1_side.thermo <= s0_thermo;
      s1_side.k      <= s0_thermo ? k_therm : cfg.time_step;
      s1_side.mass   <= s0_mass;
      s1_side.x      <= s0_x;
      s1_side.v      <= s0_v;
      s1_side.g      <= s0_g;
      s1_side.t      <= '0;
      s1_pf          <= mag_of(s0_f) * (s0_thermo ? k_therm : cfg.time_step);
      s1_fneg        <= s0_f[DATA_W-1];
      s2_side.cmd    <= s1_side.cmd;
      s2_side.thermo <= s1_side.thermo;
      s2_side.k      <= s1_side.k;
      s2_side.mass   <= s1_side.mass;
      s2_side.x      <= s1_side.x;
      s2_side.v      <= s1_side.v;
      s2_side.g      <= s1_side.g;
      s2_side.t      <= coef_scale(s1_pf, s1_fneg);
    end
  end

  lou_sqrt_pipe #(
    .IN_W   (RAD_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .radicand  ({s2_side.mass, {FRAC_BITS{1'b0}}}),
    .in_side   (s2_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side_bits)
  );

  assign sq_side = side_t'(sq_side_bits);

  lou_div_pipe #(
    .NW     (NUM_W),
    .DW     (KDEN_W),
    .SIDE_W (SIDE_W)
  ) u_kick_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .numer     ({mag_of(sq_side.t), {FRAC_BITS{1'b0}}}),
    .denom     ({sq_side.mass, 1'b0}),
    .in_side   (sq_side_bits),
    .out_valid (kd_valid),
    .quot      (kd_quot),
    .out_side  (kd_side_bits)
  );

  lou_div_pipe #(
    .NW     (COEF_W + FRAC_BITS),
    .DW     (ROOT_W),
    .SIDE_W (1)
  ) u_noise_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .numer     ({cfg.noise_scale, {FRAC_BITS{1'b0}}}),
    .denom     (sq_root),
    .in_side   (sq_side.mass == '0),
    .out_valid (cd_valid),
    .quot      (cd_quot),
    .out_side  (cd_mass_zero)
  );

  assign kd_side = side_t'(kd_side_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid <= 1'b0;
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      e4_valid <= 1'b0;
      e5_valid <= 1'b0;
      e6_valid <= 1'b0;
    end else if (en) begin
      e0_valid <= kd_valid && cd_valid;
      e1_valid <= e0_valid;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
      e4_valid <= e3_valid;
      e5_valid <= e4_valid;
      e6_valid <= e5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Kick and noise factor, with the zero-mass cases resolved here.
      e0.cmd    <= kd_side.cmd;
      e0.thermo <= kd_side.thermo;
      e0.k      <= kd_side.k;
      e0.x      <= kd_side.x;
      e0.g      <= kd_side.g;
      e0.kick   <= (kd_side.t == '0) ? '0 : sat_mag(64'(kd_quot), kd_side.t[DATA_W-1]);
      if (cd_mass_zero) e0.c <= (cfg.noise_scale == '0) ? '0 : '1;
      else if (|cd_quot[COEF_W+FRAC_BITS-1:COEF_W]) e0.c <= '1;
      else e0.c <= cd_quot[COEF_W-1:0];
      e0_v <= kd_side.v;

      // The second half applies the kick before the noise.
      e1   <= e0;
      e1_u <= e0.cmd ? sat_add(e0_v, e0.kick) : e0_v;

      e2     <= e1;
      e2_u   <= e1_u;
      e2_pv  <= mag_of(e1_u) * cfg.velocity_decay;
      e2_pvn <= e1_u[DATA_W-1];
      e2_pg  <= mag_of(e1.g) * e1.c;
      e2_pgn <= e1.g[DATA_W-1];

      e3   <= e2;
      e3_w <= e2.thermo ? sat_add(coef_scale(e2_pv, e2_pvn), coef_scale(e2_pg, e2_pgn))
                        : e2_u;

      // The first half applies the kick after the noise.
      e4   <= e3;
      e4_y <= e3.cmd ? e3_w : sat_add(e3_w, e3.kick);

      e5     <= e4;
      e5_y   <= e4_y;
      e5_px  <= mag_of(e4_y) * e4.k;
      e5_pxn <= e4_y[DATA_W-1];

      e6_v <= e5_y;
      e6_x <= e5.cmd ? e5.x : sat_add(e5.x, coef_scale(e5_px, e5_pxn));
    end
  end

  assign arrive = en && e6_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_full) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end else begin
        result_valid <= arrive;
      end
    end else if (arrive) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_full) begin
        velocity_out <= skid_v;
        position_out <= skid_x;
      end else if (arrive) begin
        velocity_out <= e6_v;
        position_out <= e6_x;
      end
    end else if (arrive) begin
      skid_v <= e6_v;
      skid_x <= e6_x;
    end
  end

endmodule

// ===== tb/sv/langevin_ovrvo_axis_update_tb.sv =====
// Self-checking testbench for the OVRVO Langevin axis update block.
module langevin_ovrvo_axis_update_tb
  import lou_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 82;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_RANDOM = 1930;

  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

  typedef struct {
    logic              cmd;
    logic [1:0]        ax;
    logic [31:0]       mass;
    logic signed [31:0] x;
    logic signed [31:0] v;
    logic signed [31:0] f;
    logic signed [31:0] g;
  } word_t;

  typedef struct {
    logic signed [31:0] v;
    logic signed [31:0] x;
  } update_t;

  typedef struct {
    word_t   w;
    logic    typed;
    update_t want;
  } row_t;

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic item_valid, item_stall;
  logic command;
  logic [1:0] axis;
  logic [MASS_W-1:0] atom_mass;
  logic signed [DATA_W-1:0] position_in, velocity_in, force_in, gauss_sample;
  logic result_valid, result_stall;
  logic signed [DATA_W-1:0] velocity_out, position_out;

  langevin_ovrvo_axis_update DUT (.*);

  // Shadow copy of the configuration registers.
  logic [31:0] sh_dt, sh_fric, sh_decay, sh_noise;
  logic sh_tx, sh_ty, sh_tz;

  update_t pending_updates[$];
  int errors = 0;
  int seen = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Signed saturation of an unbounded magnitude with a sign.
  function automatic logic signed [31:0] clamp(logic [127:0] m, logic neg);
    if (neg) begin
      if (m >= 128'h8000_0000) return 32'sh8000_0000;
      return -$signed({1'b0, m[31:0]});
    end
    if (m >= 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic logic [31:0] magn(logic signed [31:0] a);
    return a[31] ? 32'(-{1'b0, a}) : a;
  endfunction

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [33:0] s;
    s = a + b;
    if (s > 34'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -34'sh8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] scale_coef(logic signed [31:0] a, logic [31:0] c);
    logic [127:0] p;
    p = (128'(magn(a)) * 128'(c)) >> 24;
    return clamp(p, a[31]);
  endfunction

  function automatic logic signed [31:0] kick_of(logic signed [31:0] t, logic [31:0] mass);
    logic [127:0] q;
    if (mass == 0) return (t == 0) ? 32'sd0 : clamp(128'hFFFF_FFFF_FFFF, t[31]);
    q = (128'(magn(t)) << 16) / (128'(mass) * 2);
    return clamp(q, t[31]);
  endfunction

  function automatic logic [63:0] root_of(logic [63:0] n);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r |= 64'd1 << b;
    return r;
  endfunction

  function automatic logic signed [31:0] thermal(logic signed [31:0] v, logic signed [31:0] g,
                                                logic [31:0] mass);
    logic [63:0] r, q;
    logic [31:0] c;
    r = root_of(64'(mass) << 16);
    if (r == 0) c = (sh_noise == 0) ? 32'd0 : 32'hFFFF_FFFF;
    else begin
      q = (64'(sh_noise) << 16) / r;
      c = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    return add_sat(scale_coef(v, sh_decay), scale_coef(g, c));
  endfunction

  function automatic update_t predict_update(word_t w);
    update_t u;
    logic thermo;
    logic [63:0] p;
    logic [31:0] k;
    logic signed [31:0] kick, v, x;
    thermo = (w.ax == AXIS_X && sh_tx) || (w.ax == AXIS_Y && sh_ty) ||
             (w.ax == AXIS_Z && sh_tz);
    k = sh_dt;
    if (thermo) begin
      p = (64'(sh_fric) * 64'(sh_dt)) >> 24;
      k = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    end
    kick = kick_of(scale_coef(w.f, k), w.mass);
    v = w.v;
    x = w.x;
    if (w.cmd == CMD_FIRST) begin
      if (thermo) v = thermal(v, w.g, w.mass);
      v = add_sat(v, kick);
      x = add_sat(x, scale_coef(v, k));
    end else begin
      v = add_sat(v, kick);
      if (thermo) v = thermal(v, w.g, w.mass);
    end
    u.v = v;
    u.x = x;
    return u;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_TIME_STEP:      sh_dt = val;
      REG_FRICTION_SCALE: sh_fric = val;
      REG_VELOCITY_DECAY: sh_decay = val;
      REG_NOISE_SCALE:    sh_noise = val;
      REG_THERMOSTAT_X:   sh_tx = val[0];
      REG_THERMOSTAT_Y:   sh_ty = val[0];
      REG_THERMOSTAT_Z:   sh_tz = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] dt, logic [31:0] fr, logic [31:0] dc, logic [31:0] ns,
                         logic [2:0] th);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_FRICTION_SCALE, fr);
    write_reg(REG_VELOCITY_DECAY, dc);
    write_reg(REG_NOISE_SCALE, ns);
    write_reg(REG_THERMOSTAT_X, {31'd0, th[0]});
    write_reg(REG_THERMOSTAT_Y, {31'd0, th[1]});
    write_reg(REG_THERMOSTAT_Z, {31'd0, th[2]});
    cfg_write <= 0;
  endtask

  task automatic drain;
    item_valid <= 0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offers one word, with an optional random idle gap first, and waits for acceptance.
  // The valid line stays high after acceptance; an idle gap or drain drops it.
  task automatic send_word(word_t w, logic typed, update_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid   <= 1;
    command      <= w.cmd;
    axis         <= w.ax;
    atom_mass    <= w.mass;
    position_in  <= w.x;
    velocity_in  <= w.v;
    force_in     <= w.f;
    gauss_sample <= w.g;
    do @(posedge clk); while (item_stall);
    pending_updates.push_back(typed ? want : predict_update(w));
  endtask

  function automatic logic signed [31:0] rand_data();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(65535)) << $urandom_range(16));
      3: return -$signed(32'($urandom_range(65535)) << $urandom_range(14));
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w.cmd = 1'($urandom_range(1));
    w.ax = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: w.mass = $urandom_range(1, 255);
      1: w.mass = 32'($urandom_range(1, 65535)) << $urandom_range(12, 16);
      2: w.mass = 32'hFFFF_FFFF;
      default: w.mass = $urandom | 32'd1;
    endcase
    w.x = rand_data();
    w.v = rand_data();
    w.f = rand_data();
    w.g = rand_data();
    return w;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected word v=%h x=%h", $time, velocity_out, position_out);
        errors++;
      end else begin
        update_t e;
        e = pending_updates.pop_front();
        seen++;
        if (velocity_out !== e.v) begin
          $display("%0t: velocity expected %h got %h", $time, e.v, velocity_out);
          errors++;
        end
        if (position_out !== e.x) begin
          $display("%0t: position expected %h got %h", $time, e.x, position_out);
          errors++;
        end
      end
    end
  end

  // Receiver stall generator.
  always @(posedge clk) begin
    if (rst) result_stall <= 0;
    else result_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  row_t rows[$];

  initial begin
    word_t w;
    update_t none;
    none.v = 0;
    none.x = 0;
    rst = 1;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    item_valid = 0;
    command = 0;
    axis = 0;
    atom_mass = 1;
    position_in = 0;
    velocity_in = 0;
    force_in = 0;
    gauss_sample = 0;
    sh_dt = 0; sh_fric = ONE_Q24; sh_decay = ONE_Q24; sh_noise = 0;
    sh_tx = 0; sh_ty = 0; sh_tz = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // After reset the step is zero, so every word passes through unchanged.
    w = '{CMD_FIRST, AXIS_X, 32'd65536, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0};
    rows.push_back('{w, 1, '{32'sh8000_0000, 32'sh7FFF_FFFF}});
    w = '{CMD_SECOND, AXIS_Z, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF};
    rows.push_back('{w, 1, '{32'sh7FFF_FFFF, 32'sh8000_0000}});
    w = '{CMD_FIRST, 2'd3, 32'd1, 32'sd5, -32'sd7, 32'sd0, 32'sd0};
    rows.push_back('{w, 1, '{-32'sd7, 32'sd5}});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    drain();

    // Large step, full thermostat: saturation, zero mass and axis 3 cases.
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
    rows.delete();
    // Zero mass with nonzero force saturates the kick to full scale.
    w = '{CMD_SECOND, 2'd3, 32'd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0};
    rows.push_back('{w, 1, '{32'sh7FFF_FFFF, 32'sd0}});
    w = '{CMD_SECOND, 2'd3, 32'd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0};
    rows.push_back('{w, 1, '{32'sh8000_0000, 32'sd0}});
    for (int c = 0; c < 2; c++)
      for (int a = 0; a < 4; a++) begin
        w = '{c[0], a[1:0], (a == 1) ? 32'd0 : 32'd65536, 32'sd100000, -32'sd3000,
              32'sh7FFF_FFFF, 32'sh8000_0000};
        rows.push_back('{w, 0, none});
        w = '{c[0], a[1:0], 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0,
              32'sh7FFF_FFFF};
        rows.push_back('{w, 0, none});
      end
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    drain();

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (ph)
        0: set_all(32'h0004_0000, ONE_Q24, ONE_Q24, 32'h0000_0000, 3'b000);
        1: set_all(32'h0001_0000, 32'h00F0_0000, 32'h00E0_0000, 32'h0080_0000, 3'b101);
        2: set_all($urandom, $urandom, $urandom, $urandom, 3'($urandom));
        3: set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 3'b111);
        4: set_all(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 3'b010);
        5: set_all(32'h0000_4000, 32'h0200_0000, 32'h00FF_0000, 32'h0010_0000, 3'b111);
        default: set_all($urandom, $urandom, $urandom, $urandom, 3'($urandom));
      endcase
      // A long receiver hold fills the pipeline and pushes back on the sender.
      if (ph == 2) fork
        begin
          recv_hold = 1;
          repeat (300) @(posedge clk);
          recv_hold = 0;
        end
      join_none
      for (int n = 0; n < NUM_RANDOM / 8; n++) begin
        send_word(rand_word(), 0, none);
        // Once, in phase five, the sender pauses until every result is back.
        if (ph == 5 && n == 100) begin
          item_valid <= 0;
          while (pending_updates.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    recv_stall_pct = 0;
    drain();

    $display("Checked %0d updates over eight register settings,", seen);
    $display("both commands, all axes, saturation and zero-mass cases, with stalls and gaps.");
    if (errors == 0 && pending_updates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lou_pkg.sv
src/lou_cfg.sv
src/lou_sqrt_pipe.sv
src/lou_div_pipe.sv
src/langevin_ovrvo_axis_update.sv
tb/sv/langevin_ovrvo_axis_update_tb.sv
